@@ hw/rtl/gtp_pkg.sv @@
package gtp_pkg;

	localparam int MAX_SOURCES = 16;
	localparam int MAX_STEPS   = 63;

	localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
	localparam int STEP_W = 6;

	localparam int WORD_W = 32;
	localparam int DIFF_W = 33;
	localparam int PROD_W = 66;
	localparam int R2_W   = 49;
	localparam int ACC_W  = 35 + IDX_W;
	localparam int U_W    = 31;

	localparam int RAD_W    = 64;
	localparam int ROOT_W   = 32;
	localparam int QUO_W    = 32;
	localparam int DIV_N_W  = 80;
	localparam int DIV_HI_W = DIV_N_W - QUO_W;
	localparam int DIV_D_W  = 49;

	localparam int CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] GRAVITY_RESET    = 32'd65536;
	localparam logic [WORD_W-1:0] TIME_STEP_RESET  = 32'd1092;
	localparam logic [WORD_W-1:0] NEAR_LIMIT_RESET = 32'd1;
	localparam logic [U_W-1:0]    U_CAP            = 31'h4000_0000;

	typedef enum logic [1:0] {
		FN_CLEAR   = 2'd0,
		FN_ADD     = 2'd1,
		FN_PREDICT = 2'd2,
		FN_UNUSED  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAVITY    = 2'd0,
		CFG_TIME_STEP  = 2'd1,
		CFG_NEAR_LIMIT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		func_t                     func;
		logic signed [WORD_W-1:0]  source_x;
		logic signed [WORD_W-1:0]  source_y;
		logic        [WORD_W-1:0]  source_mass;
		logic signed [WORD_W-1:0]  ship_x;
		logic signed [WORD_W-1:0]  ship_y;
		logic signed [WORD_W-1:0]  ship_vx;
		logic signed [WORD_W-1:0]  ship_vy;
		logic        [STEP_W-1:0]  step_count;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] point_x;
		logic signed [WORD_W-1:0] point_y;
		logic                     last_point;
		logic                     clipped;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ADD,
		OP_LOAD,
		OP_ACC_CLR,
		OP_READ,
		OP_DIFF,
		OP_MUL_DX,
		OP_R2_X,
		OP_MUL_DY,
		OP_R2_Y,
		OP_SQRT_GO,
		OP_MUL_GM,
		OP_DIV_G_GO,
		OP_G_LATCH,
		OP_DIV_X_GO,
		OP_UX_LATCH,
		OP_DIV_Y_GO,
		OP_UY_LATCH,
		OP_MUL_TX,
		OP_ACC_X,
		OP_MUL_TY,
		OP_ACC_Y,
		OP_SAT_A,
		OP_MUL_VX,
		OP_UPD_VX,
		OP_MUL_VY,
		OP_UPD_VY,
		OP_MUL_PX,
		OP_UPD_PX,
		OP_MUL_PY,
		OP_UPD_PY,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic r_zero;
		logic sqrt_done;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

@@ hw/rtl/gtp_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module gtp_sqrt import gtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rem_q;
	logic [RAD_W-1:0]  res_q;
	logic [RAD_W-1:0]  bit_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RAD_W-1:0]  trial;
	logic              fits;

	assign trial = res_q + bit_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

@@ hw/rtl/gtp_div.sv @@
// Restoring divider, one quotient bit per cycle. The overflow flag is set when
// the quotient would not fit in QUO_W bits.
module gtp_div import gtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               done,
	output logic               ovf,
	output logic [QUO_W-1:0]   quo
);

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [QUO_W-1:0]   low_q;
	logic [QUO_W-1:0]   quo_q;
	logic               ovf_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, low_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, dividend[DIV_N_W-1:QUO_W]};
			low_q <= dividend[QUO_W-1:0];
			den_q <= divisor;
			quo_q <= '0;
			ovf_q <= {1'b0, dividend[DIV_N_W-1:QUO_W]} >= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_D_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DIV_D_W-1:0];
			end
			low_q <= low_q << 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;

endmodule

@@ hw/rtl/gtp_dp.sv @@
// Datapath: source table, configuration registers, ship state, one shared
// multiplier, the root and divide units, and the output register.
module gtp_dp import gtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  in_item_t          item,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic              point_valid,
	input  logic              point_ready,
	output out_item_t         point
);

	logic [WORD_W-1:0] grav_q, dt_q, near_q;

	logic signed [WORD_W-1:0] src_x_mem [MAX_SOURCES];
	logic signed [WORD_W-1:0] src_y_mem [MAX_SOURCES];
	logic        [WORD_W-1:0] src_m_mem [MAX_SOURCES];
	logic signed [WORD_W-1:0] sx_q, sy_q;
	logic        [WORD_W-1:0] sm_q;

	logic signed [WORD_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [DIFF_W-1:0]        mx, my;
	logic [PROD_W-1:0]        prod_q;
	logic [R2_W-1:0]          r2_q;
	logic [WORD_W-1:0]        g_q;
	logic [U_W-1:0]           ux_q, uy_q;
	logic [ACC_W-1:0]         acc_x_q, acc_y_q;
	logic                     clip_q;

	logic [DIFF_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [ACC_W-1:0]   term;
	logic [63:0]        acc_x64, acc_y64;
	logic [WORD_W-1:0]  ax_sat, ay_sat;
	logic               ax_ovf, ay_ovf;
	logic [WORD_W-1:0]  upd_base;
	logic               upd_neg;
	logic [63:0]        upd64;
	logic [WORD_W-1:0]  upd_val;
	logic               upd_ovf;
	logic [U_W-1:0]     u_new;

	logic               sqrt_go, sqrt_done;
	logic [ROOT_W-1:0]  root;
	logic               div_go, div_done, div_ovf;
	logic [DIV_N_W-1:0] dividend;
	logic [DIV_D_W-1:0] divisor;
	logic [QUO_W-1:0]   quo;

	logic               point_valid_q;
	out_item_t          point_q;

	function automatic logic sat_ovf(input logic [63:0] v);
		return !((&v[63:31]) || !(|v[63:31]));
	endfunction

	function automatic logic [31:0] sat_val(input logic [63:0] v);
		if (sat_ovf(v)) begin
			return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAVITY_RESET;
			dt_q   <= TIME_STEP_RESET;
			near_q <= NEAR_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRAVITY:    grav_q <= cfg_wdata;
				CFG_TIME_STEP:  dt_q   <= cfg_wdata;
				CFG_NEAR_LIMIT: near_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ADD) begin
			src_x_mem[cmd.idx] <= item.source_x;
			src_y_mem[cmd.idx] <= item.source_y;
			src_m_mem[cmd.idx] <= item.source_mass;
		end
		if (cmd.op == OP_READ) begin
			sx_q <= src_x_mem[cmd.idx];
			sy_q <= src_y_mem[cmd.idx];
			sm_q <= src_m_mem[cmd.idx];
		end
	end

	assign mx = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
	assign my = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_DX: begin
				mul_a = mx;
				mul_b = mx;
			end
			OP_MUL_DY: begin
				mul_a = my;
				mul_b = my;
			end
			OP_MUL_GM: begin
				mul_a = {1'b0, grav_q};
				mul_b = {1'b0, sm_q};
			end
			OP_MUL_TX: begin
				mul_a = {1'b0, g_q};
				mul_b = {2'b0, ux_q};
			end
			OP_MUL_TY: begin
				mul_a = {1'b0, g_q};
				mul_b = {2'b0, uy_q};
			end
			OP_MUL_VX: begin
				mul_a = {1'b0, abs32(acc_x_q[WORD_W-1:0])};
				mul_b = {1'b0, dt_q};
			end
			OP_MUL_VY: begin
				mul_a = {1'b0, abs32(acc_y_q[WORD_W-1:0])};
				mul_b = {1'b0, dt_q};
			end
			OP_MUL_PX: begin
				mul_a = {1'b0, abs32(vel_x_q)};
				mul_b = {1'b0, dt_q};
			end
			OP_MUL_PY: begin
				mul_a = {1'b0, abs32(vel_y_q)};
				mul_b = {1'b0, dt_q};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// A pull term is at most 2^32, so it fits the accumulator with room for
	// every source.
	assign term    = {{(ACC_W-33){1'b0}}, prod_q[62:30]};
	assign acc_x64 = {{(64-ACC_W){acc_x_q[ACC_W-1]}}, acc_x_q};
	assign acc_y64 = {{(64-ACC_W){acc_y_q[ACC_W-1]}}, acc_y_q};
	assign ax_sat  = sat_val(acc_x64);
	assign ay_sat  = sat_val(acc_y64);
	assign ax_ovf  = sat_ovf(acc_x64);
	assign ay_ovf  = sat_ovf(acc_y64);

	always_comb begin
		upd_base = pos_y_q;
		upd_neg  = vel_y_q[WORD_W-1];
		case (cmd.op)
			OP_UPD_VX: begin
				upd_base = vel_x_q;
				upd_neg  = acc_x_q[WORD_W-1];
			end
			OP_UPD_VY: begin
				upd_base = vel_y_q;
				upd_neg  = acc_y_q[WORD_W-1];
			end
			OP_UPD_PX: begin
				upd_base = pos_x_q;
				upd_neg  = vel_x_q[WORD_W-1];
			end
			default: ;
		endcase
	end

	// The scaled step truncates toward zero: magnitude first, sign after.
	assign upd64 = upd_neg
		? ({{32{upd_base[31]}}, upd_base} - {17'b0, prod_q[62:16]})
		: ({{32{upd_base[31]}}, upd_base} + {17'b0, prod_q[62:16]});
	assign upd_val = sat_val(upd64);
	assign upd_ovf = sat_ovf(upd64);

	assign u_new = div_ovf ? U_CAP
		: ((quo > {1'b0, U_CAP}) ? U_CAP : quo[U_W-1:0]);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				pos_x_q <= item.ship_x;
				pos_y_q <= item.ship_y;
				vel_x_q <= item.ship_vx;
				vel_y_q <= item.ship_vy;
				clip_q  <= 1'b0;
			end
			OP_ACC_CLR: begin
				acc_x_q <= '0;
				acc_y_q <= '0;
			end
			OP_DIFF: begin
				dx_q <= DIFF_W'(sx_q) - DIFF_W'(pos_x_q);
				dy_q <= DIFF_W'(sy_q) - DIFF_W'(pos_y_q);
			end
			OP_R2_X: r2_q <= R2_W'(prod_q[63:16]);
			OP_R2_Y: r2_q <= r2_q + R2_W'(prod_q[63:16]);
			OP_G_LATCH: begin
				g_q <= div_ovf ? 32'hFFFF_FFFF : quo;
				if (div_ovf) begin
					clip_q <= 1'b1;
				end
			end
			OP_UX_LATCH: ux_q <= u_new;
			OP_UY_LATCH: uy_q <= u_new;
			OP_ACC_X: acc_x_q <= dx_q[DIFF_W-1] ? acc_x_q - term : acc_x_q + term;
			OP_ACC_Y: acc_y_q <= dy_q[DIFF_W-1] ? acc_y_q - term : acc_y_q + term;
			OP_SAT_A: begin
				acc_x_q <= {{(ACC_W-32){ax_sat[31]}}, ax_sat};
				acc_y_q <= {{(ACC_W-32){ay_sat[31]}}, ay_sat};
				if (ax_ovf || ay_ovf) begin
					clip_q <= 1'b1;
				end
			end
			OP_UPD_VX, OP_UPD_VY, OP_UPD_PX, OP_UPD_PY: begin
				if (cmd.op == OP_UPD_VX) vel_x_q <= upd_val;
				if (cmd.op == OP_UPD_VY) vel_y_q <= upd_val;
				if (cmd.op == OP_UPD_PX) pos_x_q <= upd_val;
				if (cmd.op == OP_UPD_PY) pos_y_q <= upd_val;
				if (upd_ovf) begin
					clip_q <= 1'b1;
				end
			end
			OP_MUL_DX, OP_MUL_DY, OP_MUL_GM, OP_MUL_TX, OP_MUL_TY,
			OP_MUL_VX, OP_MUL_VY, OP_MUL_PX, OP_MUL_PY: prod_q <= mul_p;
			default: ;
		endcase
	end

	assign sqrt_go = cmd.op == OP_SQRT_GO;

	gtp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sqrt_go),
		.radicand ({1'b0, r2_q, 14'b0}),
		.done     (sqrt_done),
		.root     (root)
	);

	assign div_go = (cmd.op == OP_DIV_G_GO) || (cmd.op == OP_DIV_X_GO)
		|| (cmd.op == OP_DIV_Y_GO);

	always_comb begin
		dividend = {prod_q[63:0], 16'b0};
		divisor  = r2_q;
		if (cmd.op == OP_DIV_X_GO) begin
			dividend = {18'b0, mx, 29'b0};
			divisor  = {17'b0, root};
		end else if (cmd.op == OP_DIV_Y_GO) begin
			dividend = {18'b0, my, 29'b0};
			divisor  = {17'b0, root};
		end
	end

	gtp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.ovf      (div_ovf),
		.quo      (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			point_valid_q <= 1'b1;
		end else if (point_ready) begin
			point_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			point_q.point_x    <= pos_x_q;
			point_q.point_y    <= pos_y_q;
			point_q.last_point <= cmd.last;
			point_q.clipped    <= clip_q;
		end
	end

	assign point_valid   = point_valid_q;
	assign point         = point_q;
	assign sts.skip      = (r2_q == '0) || (r2_q < {17'b0, near_q});
	assign sts.r_zero    = root == '0;
	assign sts.sqrt_done = sqrt_done;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !point_valid_q || point_ready;

endmodule

@@ hw/rtl/gtp_ctrl.sv @@
// Sequencer: decodes input beats, walks the steps and the source table, and
// issues one datapath operation per cycle, save while it waits on the root, the divider or the output register.
module gtp_ctrl import gtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  func_t             item_func,
	input  logic [STEP_W-1:0] item_steps,
	output logic              item_ready,
	output dp_cmd_t           cmd,
	input  dp_sts_t           sts
);

	typedef enum logic [5:0] {
		ST_IDLE, ST_EMIT, ST_ACC_CLR, ST_RD, ST_DIFF, ST_MULX, ST_R2X, ST_MULY,
		ST_R2Y, ST_CHK, ST_SQRT, ST_SQRT_W, ST_MULGM, ST_DIVG, ST_DIVG_W,
		ST_DIVX, ST_DIVX_W, ST_DIVY, ST_DIVY_W, ST_MTX, ST_ACCX, ST_MTY,
		ST_ACCY, ST_NEXT, ST_SATA, ST_MVX, ST_UVX, ST_MVY, ST_UVY, ST_MPX,
		ST_UPX, ST_MPY, ST_UPY
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] steps_q;
	logic              accept;
	logic              last_src;
	logic              last_step;
	logic [STEP_W-1:0] steps_in;

	assign item_ready = state_q == ST_IDLE;
	assign accept     = item_valid && item_ready;
	assign last_src   = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign last_step  = step_q == steps_q;
	assign steps_in   = (item_steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
		: item_steps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			step_q  <= '0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item_func)
							FN_CLEAR: count_q <= '0;
							FN_ADD: begin
								if (count_q < CNT_W'(MAX_SOURCES)) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							FN_PREDICT: begin
								steps_q <= steps_in;
								step_q  <= '0;
								state_q <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (last_step) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q + STEP_W'(1);
							state_q <= ST_ACC_CLR;
						end
					end
				end
				ST_ACC_CLR: begin
					idx_q   <= '0;
					state_q <= (count_q == '0) ? ST_SATA : ST_RD;
				end
				ST_RD:   state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MULX;
				ST_MULX: state_q <= ST_R2X;
				ST_R2X:  state_q <= ST_MULY;
				ST_MULY: state_q <= ST_R2Y;
				ST_R2Y:  state_q <= ST_CHK;
				ST_CHK:  state_q <= sts.skip ? ST_NEXT : ST_SQRT;
				ST_SQRT: state_q <= ST_SQRT_W;
				ST_SQRT_W: begin
					if (sts.sqrt_done) begin
						state_q <= sts.r_zero ? ST_NEXT : ST_MULGM;
					end
				end
				ST_MULGM: state_q <= ST_DIVG;
				ST_DIVG:  state_q <= ST_DIVG_W;
				ST_DIVG_W: if (sts.div_done) state_q <= ST_DIVX;
				ST_DIVX:  state_q <= ST_DIVX_W;
				ST_DIVX_W: if (sts.div_done) state_q <= ST_DIVY;
				ST_DIVY:  state_q <= ST_DIVY_W;
				ST_DIVY_W: if (sts.div_done) state_q <= ST_MTX;
				ST_MTX:  state_q <= ST_ACCX;
				ST_ACCX: state_q <= ST_MTY;
				ST_MTY:  state_q <= ST_ACCY;
				ST_ACCY: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (last_src) begin
						state_q <= ST_SATA;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_SATA: state_q <= ST_MVX;
				ST_MVX:  state_q <= ST_UVX;
				ST_UVX:  state_q <= ST_MVY;
				ST_MVY:  state_q <= ST_UVY;
				ST_UVY:  state_q <= ST_MPX;
				ST_MPX:  state_q <= ST_UPX;
				ST_UPX:  state_q <= ST_MPY;
				ST_MPY:  state_q <= ST_UPY;
				ST_UPY:  state_q <= ST_EMIT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.idx  = idx_q;
		cmd.last = last_step;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item_func == FN_ADD
					&& count_q < CNT_W'(MAX_SOURCES)) begin
					cmd.op  = OP_ADD;
					cmd.idx = IDX_W'(count_q);
				end else if (accept && item_func == FN_PREDICT) begin
					cmd.op = OP_LOAD;
				end
			end
			ST_EMIT:    cmd.op = sts.out_free ? OP_EMIT : OP_NOP;
			ST_ACC_CLR: cmd.op = OP_ACC_CLR;
			ST_RD:      cmd.op = OP_READ;
			ST_DIFF:    cmd.op = OP_DIFF;
			ST_MULX:    cmd.op = OP_MUL_DX;
			ST_R2X:     cmd.op = OP_R2_X;
			ST_MULY:    cmd.op = OP_MUL_DY;
			ST_R2Y:     cmd.op = OP_R2_Y;
			ST_SQRT:    cmd.op = OP_SQRT_GO;
			ST_MULGM:   cmd.op = OP_MUL_GM;
			ST_DIVG:    cmd.op = OP_DIV_G_GO;
			ST_DIVG_W:  cmd.op = sts.div_done ? OP_G_LATCH : OP_NOP;
			ST_DIVX:    cmd.op = OP_DIV_X_GO;
			ST_DIVX_W:  cmd.op = sts.div_done ? OP_UX_LATCH : OP_NOP;
			ST_DIVY:    cmd.op = OP_DIV_Y_GO;
			ST_DIVY_W:  cmd.op = sts.div_done ? OP_UY_LATCH : OP_NOP;
			ST_MTX:     cmd.op = OP_MUL_TX;
			ST_ACCX:    cmd.op = OP_ACC_X;
			ST_MTY:     cmd.op = OP_MUL_TY;
			ST_ACCY:    cmd.op = OP_ACC_Y;
			ST_SATA:    cmd.op = OP_SAT_A;
			ST_MVX:     cmd.op = OP_MUL_VX;
			ST_UVX:     cmd.op = OP_UPD_VX;
			ST_MVY:     cmd.op = OP_MUL_VY;
			ST_UVY:     cmd.op = OP_UPD_VY;
			ST_MPX:     cmd.op = OP_MUL_PX;
			ST_UPX:     cmd.op = OP_UPD_PX;
			ST_MPY:     cmd.op = OP_MUL_PY;
			ST_UPY:     cmd.op = OP_UPD_PY;
			default:    cmd.op = OP_NOP;
		endcase
	end

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> sts.out_free)
		else $error("point issued while output register is occupied");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SOURCES))
		else $error("source count beyond table size");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> step_q <= steps_q)
		else $error("step counter ran past the requested count");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_READ |-> CNT_W'(idx_q) < count_q)
		else $error("source read beyond the loaded entries");

endmodule

@@ hw/rtl/gravity_trajectory_predictor.sv @@
// Trajectory predictor for a ship moving among fixed point-mass gravity sources.
// Input beats on the item channel carry a function code. A clear beat empties
// the source table, an add beat appends one source (ignored once the table
// holds MAX_SOURCES), and a predict beat starts a path from the given position
// and velocity. Clear and add produce no output beat.
// A predict beat produces step_count + 1 output beats on the point channel
// (step_count is cut to MAX_STEPS): the start point, then one point per
// symplectic Euler step, the final one marked with last_point.
// Each step walks the source table on a shared 33x33 multiplier, a bit-serial
// square root and a bit-serial divider, and skips a source that lies too near.
// The divider runs three times and the root once per source that is not
// skipped. One item is worked at a time: item_ready is high only between
// paths. The result sits in an output register; while the receiver stalls,
// the block holds at the next point until that register is free.
// Reset clears the source table count and loads the default gravity constant,
// time step and near limit. Configuration writes take effect at once and are
// meant for idle periods only.
module gravity_trajectory_predictor import gtp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  in_item_t             item,
	output logic                 point_valid,
	input  logic                 point_ready,
	output out_item_t            point,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata
);

	// Commands from the sequencer, status back from the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	gtp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_func  (item.func),
		.item_steps (item.step_count),
		.item_ready (item_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	gtp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.item        (item),
		.cmd         (cmd),
		.sts         (sts),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point       (point)
	);

endmodule

@@ dv/gtp_path_checker.sv @@
module gtp_path_checker import gtp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  in_item_t             item,
	input  logic                 point_valid,
	input  logic                 point_ready,
	input  out_item_t            point,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	output int                   mismatches,
	output int                   points_due,
	output int                   points_seen,
	output int                   paths_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Local copy of the source table and registers.
	logic signed [WORD_W-1:0] src_x [MAX_SOURCES];
	logic signed [WORD_W-1:0] src_y [MAX_SOURCES];
	logic        [WORD_W-1:0] src_mass [MAX_SOURCES];
	int                       src_total;
	logic        [WORD_W-1:0] grav, dt, near_lim;
	out_item_t                path_points [$];

	function automatic longint unsigned magn(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint clamp(longint v, inout bit clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Pull strength G*m/r2 in Q16.16, saturating at the all-ones word.
	function automatic longint unsigned pull_strength(longint unsigned num,
			longint unsigned den, inout bit clip);
		longint unsigned q, rem;
		q = num / den;
		rem = num % den;
		if (q > 64'hFFFF) begin
			clip = 1'b1;
			return 64'hFFFF_FFFF;
		end
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// Product with dt, truncated toward zero.
	function automatic longint scale_dt(longint x);
		longint unsigned m;
		m = (magn(x) * longint'(dt)) >> 16;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint axis_pull(longint d, longint unsigned r, longint unsigned g);
		longint unsigned u, m;
		u = (magn(d) << 29) / r;
		if (u > (64'd1 << 30))
			u = 64'd1 << 30;
		m = (g * u) >> 30;
		return (d < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic void predict_path(in_item_t it);
		longint px, py, vx, vy, ax, ay, dx, dy;
		longint unsigned mx, my, r2, r, g;
		int n;
		bit clip;
		out_item_t pt;
		n = int'(it.step_count);
		if (n > MAX_STEPS)
			n = MAX_STEPS;
		px = it.ship_x;
		py = it.ship_y;
		vx = it.ship_vx;
		vy = it.ship_vy;
		clip = 1'b0;
		pt.point_x = px[31:0];
		pt.point_y = py[31:0];
		pt.last_point = (n == 0);
		pt.clipped = 1'b0;
		path_points.insert(path_points.size(), pt);
		for (int s = 1; s <= n; s++) begin
			ax = 0;
			ay = 0;
			for (int i = 0; i < src_total; i++) begin
				dx = longint'(src_x[i]) - px;
				dy = longint'(src_y[i]) - py;
				mx = magn(dx);
				my = magn(dy);
				r2 = ((mx * mx) >> 16) + ((my * my) >> 16);
				if (r2 == 0 || r2 < longint'(near_lim))
					continue;
				r = root64(r2 << 14);
				if (r == 0)
					continue;
				g = pull_strength(longint'(grav) * longint'(src_mass[i]), r2, clip);
				ax += axis_pull(dx, r, g);
				ay += axis_pull(dy, r, g);
			end
			ax = clamp(ax, clip);
			ay = clamp(ay, clip);
			vx = clamp(vx + scale_dt(ax), clip);
			vy = clamp(vy + scale_dt(ay), clip);
			px = clamp(px + scale_dt(vx), clip);
			py = clamp(py + scale_dt(vy), clip);
			pt.point_x = px[31:0];
			pt.point_y = py[31:0];
			pt.last_point = (s == n);
			pt.clipped = clip;
			path_points.insert(path_points.size(), pt);
		end
	endfunction

	function automatic void report(string what, out_item_t want, out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s point %0d: expected x=%h y=%h last=%b clip=%b,%s%h y=%h last=%b clip=%b",
				$realtime, what, points_seen, want.point_x, want.point_y, want.last_point,
				want.clipped, " got x=", got.point_x, got.point_y, got.last_point,
				got.clipped);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			src_total = 0;
			grav = GRAVITY_RESET;
			dt = TIME_STEP_RESET;
			near_lim = NEAR_LIMIT_RESET;
			path_points.delete();
			mismatches = 0;
			points_seen = 0;
			paths_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_GRAVITY:    grav = cfg_wdata;
					CFG_TIME_STEP:  dt = cfg_wdata;
					CFG_NEAR_LIMIT: near_lim = cfg_wdata;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				case (item.func)
					FN_CLEAR: src_total = 0;
					FN_ADD: begin
						if (src_total < MAX_SOURCES) begin
							src_x[src_total] = item.source_x;
							src_y[src_total] = item.source_y;
							src_mass[src_total] = item.source_mass;
							src_total++;
						end
					end
					FN_PREDICT: begin
						predict_path(item);
						paths_seen++;
					end
					default: ;
				endcase
			end
			if (point_valid && point_ready) begin
				if (path_points.size() == 0) begin
					want = '0;
					report("unexpected", want, point);
				end else begin
					want = path_points.pop_front();
					if (point.point_x !== want.point_x || point.point_y !== want.point_y ||
							point.last_point !== want.last_point ||
							point.clipped !== want.clipped)
						report("wrong", want, point);
				end
				points_seen++;
			end
		end
		points_due = path_points.size();
	end

endmodule

@@ dv/gravity_trajectory_predictor_test.sv @@
module gravity_trajectory_predictor_test import gtp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 72;
	localparam int PHASES         = 4;
	localparam int QUIET_TAIL     = 20;
	localparam int HOLD_CYCLES    = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_ready;
	in_item_t             item;
	logic                 point_valid;
	logic                 point_ready;
	out_item_t            point;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_wdata;

	int  mismatches, points_due, points_seen, paths_seen;
	int  items_sent;
	int  idle_cycles;
	bit  quiet;
	bit  hold_req;

	gravity_trajectory_predictor dut (.*);

	// The checker sits beside the block, sees every beat and owns the verdict data.
	gtp_path_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that moves no beat for too long is declared hung.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (point_valid && point_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver side. It stalls in random bursts, and on request holds off for a
	// long stretch so that the output register stays full and the block backs up
	// onto its input. Near the end of the run it accepts every beat.
	initial begin
		point_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				point_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				point_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				point_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Offer one beat and hold it until the block takes it. Readiness is looked at
	// on the falling edge, where it is stable, and the beat moves on the next
	// rising edge.
	task automatic send(in_item_t it);
		bit taken;
		item <= it;
		item_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = item_ready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	// Sender gaps come in random bursts, except in the quiet tail.
	task automatic maybe_pause();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	function automatic in_item_t noise_item();
		in_item_t it;
		it.func = func_t'($urandom_range(0, 3));
		it.source_x = $urandom;
		it.source_y = $urandom;
		it.source_mass = $urandom;
		it.ship_x = $urandom;
		it.ship_y = $urandom;
		it.ship_vx = $urandom;
		it.ship_vy = $urandom;
		it.step_count = STEP_W'($urandom);
		return it;
	endfunction

	// A coordinate within a modest playfield, in Q16.16.
	function automatic logic signed [WORD_W-1:0] field_coord(int span);
		return $signed($urandom_range(0, 2 * span * 65536)) - span * 65536;
	endfunction

	function automatic in_item_t source_item(int span);
		in_item_t it;
		it = noise_item();
		it.func = FN_ADD;
		it.source_x = field_coord(span);
		it.source_y = field_coord(span);
		it.source_mass = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 200000);
		return it;
	endfunction

	function automatic in_item_t path_item(int span, int steps);
		in_item_t it;
		it = noise_item();
		it.func = FN_PREDICT;
		it.ship_x = field_coord(span);
		it.ship_y = field_coord(span);
		it.ship_vx = field_coord(8);
		it.ship_vy = field_coord(8);
		it.step_count = STEP_W'(steps);
		return it;
	endfunction

	function automatic in_item_t clear_item();
		in_item_t it;
		it = noise_item();
		it.func = FN_CLEAR;
		return it;
	endfunction

	// Wait until every predicted point has come back, then a few more cycles so
	// that a trailing clear or add has settled before the next register write.
	task automatic drain(int extra);
		item_valid <= 1'b0;
		do @(negedge clk); while (points_due != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_regs(logic [WORD_W-1:0] g, logic [WORD_W-1:0] step,
			logic [WORD_W-1:0] near);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRAVITY;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= CFG_TIME_STEP;
		cfg_wdata <= step;
		@(posedge clk);
		cfg_index <= CFG_NEAR_LIMIT;
		cfg_wdata <= near;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_item_t it;
		int sent_random, n_src, steps;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_GRAVITY;
		cfg_wdata = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset register values.
		// With an empty table and zero steps the start point alone ends the path.
		it = noise_item();
		it.func = FN_PREDICT;
		it.ship_x = 32'sh7FFF_FFFF;
		it.ship_vx = 32'sh7FFF_FFFF;
		it.step_count = STEP_W'(0);
		send(it);
		// Extreme start state: the position runs into the signed limits.
		it.ship_x = 32'sh7FFF_FFFF;
		it.ship_y = 32'sh8000_0000;
		it.ship_vx = 32'sh7FFF_FFFF;
		it.ship_vy = 32'sh8000_0000;
		it.step_count = STEP_W'(3);
		send(it);
		// One real source, and one on top of the ship that must be skipped.
		send(clear_item());
		it = source_item(20);
		it.source_x = 10 << 16;
		it.source_y = 0;
		it.source_mass = 1000;
		send(it);
		it.source_x = 0;
		it.source_mass = 32'hFFFF_FFFF;
		send(it);
		it = path_item(0, 5);
		it.ship_x = 0;
		it.ship_y = 0;
		send(it);
		// The unused function code does nothing.
		it = noise_item();
		it.func = FN_UNUSED;
		send(it);
		// Fill the table, then one add too many, then the longest path. The
		// receiver holds off meanwhile, so the next item waits at the input.
		send(clear_item());
		repeat (MAX_SOURCES + 1) send(source_item(40));
		hold_req = 1'b1;
		send(path_item(40, MAX_STEPS));
		send(clear_item());
		drain(8);

		// Strong pull: a huge mass right next to the ship saturates the strength.
		write_regs(32'hFFFF_FFFF, 32'd65536, 32'd0);
		it = source_item(4);
		it.source_x = 1 << 16;
		it.source_y = 0;
		it.source_mass = 32'hFFFF_FFFF;
		send(it);
		it = path_item(0, 2);
		it.ship_x = 0;
		it.ship_y = 0;
		send(it);
		drain(8);

		// Random phases. Most rounds are a clear (usually), a few adds and a path; the rest
		// is noise over every field and function code. Each phase starts idle
		// with a fresh register setting, the extremes among them.
		sent_random = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_regs(GRAVITY_RESET, TIME_STEP_RESET, NEAR_LIMIT_RESET);
				1: write_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: write_regs($urandom, $urandom_range(0, 8192), $urandom_range(0, 1 << 20));
				default: write_regs($urandom_range(1 << 16, 1 << 24), 32'd0, 32'd0);
			endcase
			while (sent_random < (phase + 1) * RANDOM_ITEMS / PHASES) begin
				quiet = (sent_random >= RANDOM_ITEMS - QUIET_TAIL);
				maybe_pause();
				if ($urandom_range(0, 4) == 0) begin
					send(noise_item());
					sent_random++;
				end else begin
					if ($urandom_range(0, 3) != 0) begin
						send(clear_item());
						sent_random++;
					end
					n_src = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_SOURCES + 2)
						: $urandom_range(0, 3);
					repeat (n_src) begin
						maybe_pause();
						send(source_item(50));
						sent_random++;
					end
					steps = ($urandom_range(0, 9) == 0) ? MAX_STEPS : $urandom_range(0, 12);
					maybe_pause();
					send(path_item(50, steps));
					sent_random++;
				end
			end
			drain(8);
		end

		drain(50);
		$display("Covered %0d input beats, %0d paths, %0d path points checked,",
			items_sent, paths_seen, points_seen);
		$display("across default, extreme and random register settings.");
		if (mismatches == 0 && points_due == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d points never arrived", mismatches, points_due);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
